/* sv/tip_pkg.sv */
// shared types and constants for the trapezoid interface position block
// no dependencies; used by tip_mul, tip_div and the top level
`default_nettype none

package tip_pkg;

    localparam int DIST_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int AREA_W  = 48;
    localparam int POS_W   = 24;
    localparam int STAT_W  = 2;

    // shared multiplier: 25-bit signed by 18-bit signed
    localparam int MUL_A_W = DIST_W + 1;
    localparam int MUL_B_W = LEVEL_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // numerator and serial divider widths
    localparam int NUM_W  = 50;
    localparam int QUO_W  = NUM_W - 1;
    localparam int DIVS_W = LEVEL_W;
    localparam int CNT_W  = 6;

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

    // quotient magnitude limits for positive and negative results
    localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'(POS_MAX);
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_POS_LIM + QUO_W'(1);

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT      = 2'd2;

    // register index bit of the configuration address
    localparam logic REG_LEFT  = 1'b0;
    localparam logic REG_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG_ACC,
        ST_LEFT_MUL,
        ST_LEFT_ACC,
        ST_RIGHT_ACC,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } tip_state_t;

    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

/* sv/tip_mul.sv */
// shared signed multiplier with a registered product
// depends on tip_pkg
`default_nettype none

module tip_mul
    import tip_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]       prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* sv/tip_div.sv */
// serial restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on tip_pkg
`default_nettype none

module tip_div
    import tip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_req_t  req,
    output div_stat_t      stat
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;
    logic [DIVS_W-1:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_step = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/trapezoid_interface_position_top.sv */
// trapezoid interface position: top level with sequencer, accumulator and apb registers
// depends on tip_pkg, tip_mul (shared multiplier) and tip_div (serial divider)
//
// usage:
// - slave stream takes one profile sample per transaction: s_tdata holds the
//   signed q16.8 distance and the unsigned q4.12 level, s_tlast marks the final
//   sample of a profile
// - each sample but a profile's first adds a trapezoid (distance step times level sum,
//   halved) to a saturating 48-bit area accumulator; first and latest distance are kept
// - on the final sample one result transaction leaves on the master stream:
//   area (q28.20), interface position (q16.8, saturated) and a status in m_tuser
//   (0 ok, 1 equal plateaus with position 0, 2 position saturated)
// - a sample that is not final goes through the product in the shared multiplier,
//   then the accumulate; s_tready is high only between samples
// - a final sample runs the last segment, the two plateau products, the divider
//   start, the wait on the serial divider (49 quotient bits, one per cycle) and
//   the output load; with equal plateaus the divider is skipped and the result
//   loads straight after the plateau products
// - the result sits in an output register; the next profile may start while it
//   waits, and a new result waits in the sequencer until m_tready frees it
// - plateau levels are written over apb at 0x0 (left) and 0x4 (right)
// - reset clears the plateaus, the profile state and the output valid flag
`default_nettype none

module trapezoid_interface_position_top
    import tip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // slave stream: [23:0] sample_distance, [39:24] sample_level
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tlast,

    // master stream: [47:0] area, [71:48] interface_position
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser,

    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [LEVEL_W-1:0] lp_reg;
    logic [LEVEL_W-1:0] rp_reg;
    logic               cfg_wr;

    // sequencer and profile state
    tip_state_t                state_reg, state_next;
    logic signed [DIST_W-1:0]  first_reg, first_next;
    logic signed [DIST_W-1:0]  prev_reg, prev_next;
    logic [LEVEL_W-1:0]        plev_reg, plev_next;
    logic signed [AREA_W-1:0]  area_reg, area_next;
    logic                      have_reg, have_next;

    // captured sample
    logic signed [DIST_W-1:0]  d_reg;
    logic [LEVEL_W-1:0]        c_reg;
    logic                      last_reg;

    // numerator and quotient sign
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic                      neg_reg, neg_next;

    // output register
    logic                      m_tvalid_reg, m_tvalid_next;
    logic signed [AREA_W-1:0]  out_area_reg, out_area_next;
    logic signed [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [STAT_W-1:0]         out_stat_reg, out_stat_next;

    // datapath signals
    logic                      s_accept;
    logic signed [DIST_W-1:0]  s_dist;
    logic [LEVEL_W-1:0]        s_level;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  half;
    logic signed [AREA_W:0]    area_sum;
    logic signed [NUM_W-1:0]   num_neg;
    logic signed [LEVEL_W:0]   den;
    logic signed [LEVEL_W:0]   den_neg;
    logic                      load_out;
    logic [POS_W-1:0]          pos_res;
    logic [STAT_W-1:0]         stat_res;
    logic [QUO_W-1:0]          quo;

    div_req_t  div_req;
    div_stat_t div_stat;

    // apb: always ready, index taken from address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_RIGHT) ? {16'b0, rp_reg} : {16'b0, lp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
            rp_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LEFT)
            begin
                lp_reg <= pwdata[LEVEL_W-1:0];
            end
            else
            begin
                rp_reg <= pwdata[LEVEL_W-1:0];
            end
        end
    end

    assign s_dist   = s_tdata[DIST_W-1:0];
    assign s_level  = s_tdata[DIST_W+LEVEL_W-1:DIST_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    tip_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    tip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // fixed datapath pieces
    always_comb
    begin
        half     = prod >>> 1;
        area_sum = {area_reg[AREA_W-1], area_reg} + (AREA_W+1)'(half);
        num_neg  = -num_reg;
        den      = {1'b0, lp_reg} - {1'b0, rp_reg};
        den_neg  = -den;
        quo      = div_stat.quotient;
        load_out = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

        // final position and status from the quotient magnitude
        if (den == '0)
        begin
            pos_res  = '0;
            stat_res = STAT_ZERO_DEN;
        end
        else if (neg_reg)
        begin
            if (quo > QUO_NEG_LIM)
            begin
                pos_res  = POS_MIN;
                stat_res = STAT_SAT;
            end
            else
            begin
                pos_res  = -quo[POS_W-1:0];
                stat_res = STAT_OK;
            end
        end
        else if (quo > QUO_POS_LIM)
        begin
            pos_res  = POS_MAX;
            stat_res = STAT_SAT;
        end
        else
        begin
            pos_res  = quo[POS_W-1:0];
            stat_res = STAT_OK;
        end
    end

    // sequencer: next state, operand selection and register updates
    always_comb
    begin
        state_next    = state_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        plev_next     = plev_reg;
        area_next     = area_reg;
        have_next     = have_reg;
        num_next      = num_reg;
        neg_next      = neg_reg;
        out_area_next = out_area_reg;
        out_pos_next  = out_pos_reg;
        out_stat_next = out_stat_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        mul_a         = '0;
        mul_b         = '0;
        div_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // segment product straight from the incoming sample
                mul_a = {s_dist[DIST_W-1], s_dist} - {prev_reg[DIST_W-1], prev_reg};
                mul_b = {2'b00, s_level} + {2'b00, plev_reg};
                if (s_accept)
                begin
                    state_next = ST_SEG_ACC;
                end
            end

            ST_SEG_ACC:
            begin
                if (have_reg)
                begin
                    if (area_sum[AREA_W] != area_sum[AREA_W-1])
                    begin
                        area_next = area_sum[AREA_W] ? AREA_MIN : AREA_MAX;
                    end
                    else
                    begin
                        area_next = area_sum[AREA_W-1:0];
                    end
                end
                else
                begin
                    first_next = d_reg;
                    area_next  = '0;
                end
                prev_next  = d_reg;
                plev_next  = c_reg;
                have_next  = 1'b1;
                state_next = last_reg ? ST_LEFT_MUL : ST_IDLE;
            end

            ST_LEFT_MUL:
            begin
                mul_a      = {first_reg[DIST_W-1], first_reg};
                mul_b      = {2'b00, lp_reg};
                state_next = ST_LEFT_ACC;
            end

            ST_LEFT_ACC:
            begin
                mul_a      = {d_reg[DIST_W-1], d_reg};
                mul_b      = {2'b00, rp_reg};
                num_next   = NUM_W'(area_reg) + NUM_W'(prod);
                state_next = ST_RIGHT_ACC;
            end

            ST_RIGHT_ACC:
            begin
                num_next   = num_reg - NUM_W'(prod);
                state_next = (den == '0) ? ST_OUT : ST_DIV_START;
            end

            ST_DIV_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg[NUM_W-1] ? num_neg[QUO_W-1:0] : num_reg[QUO_W-1:0];
                div_req.divisor  = den[LEVEL_W] ? den_neg[DIVS_W-1:0] : den[DIVS_W-1:0];
                neg_next         = num_reg[NUM_W-1] ^ den[LEVEL_W];
                state_next       = ST_DIV;
            end

            ST_DIV:
            begin
                if (!div_stat.busy)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (load_out)
                begin
                    out_area_next = area_reg;
                    out_pos_next  = pos_res;
                    out_stat_next = stat_res;
                    m_tvalid_next = 1'b1;
                    // profile done, next sample opens a new one
                    first_next    = '0;
                    prev_next     = '0;
                    plev_next     = '0;
                    area_next     = '0;
                    have_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            first_reg    <= '0;
            prev_reg     <= '0;
            plev_reg     <= '0;
            area_reg     <= '0;
            have_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            first_reg    <= first_next;
            prev_reg     <= prev_next;
            plev_reg     <= plev_next;
            area_reg     <= area_next;
            have_reg     <= have_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            d_reg    <= s_dist;
            c_reg    <= s_level;
            last_reg <= s_tlast;
        end
        num_reg      <= num_next;
        neg_reg      <= neg_next;
        out_area_reg <= out_area_next;
        out_pos_reg  <= out_pos_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_pos_reg, out_area_reg};
    assign m_tuser  = out_stat_reg;

    // an accepted sample is always followed by its accumulate cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg == ST_SEG_ACC)
        else $error("sample accepted without accumulate step");

    // the divider is running on the first wait cycle after its start
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && $past(state_reg) == ST_DIV_START) |-> div_stat.busy)
        else $error("divider not started");

    // equal plateaus always report a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_stat_reg == STAT_ZERO_DEN) |-> out_pos_reg == '0)
        else $error("zero divisor with nonzero position");

    // a result load closes the profile
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> !have_reg && m_tvalid_reg)
        else $error("profile state not cleared after result");

    // a saturated status only carries one of the two range limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_stat_reg == STAT_SAT)
            |-> (out_pos_reg == POS_MAX || out_pos_reg == POS_MIN))
        else $error("saturated status without limit value");

endmodule

`default_nettype wire
